/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent checks, clocked on a rising edge with an
// active-low reset that disables the check.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("%m: check failed");

// Expression must never be true at a rising edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  `ASSERT_AT(lbl, clk, rst_n, !(expr))

`endif

/* rtl/mrr_pkg.sv */
// ---------------------------------------------------------------------------
// mrr_pkg
// Types and constants for the matrix ring rotator.
// ---------------------------------------------------------------------------
package mrr_pkg;

  // Default store geometry
  localparam int DefMaxRows = 64;
  localparam int DefMaxCols = 64;

  // Command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_NUM_ROWS    = 2'd0;
  localparam logic [1:0] REG_NUM_COLS    = 2'd1;
  localparam logic [1:0] REG_RING_NUMBER = 2'd2;
  localparam logic [1:0] REG_ROTATE_BY   = 2'd3;

  // Steps of the bit-serial remainder unit (one per bit of |rotate_by|)
  localparam int DivSteps = 16;

  // Signed ring coordinate, wide enough for every corner and walk index
  typedef logic signed [9:0] coord_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOCATE,
    ST_DIV,
    ST_WRAP,
    ST_POS,
    ST_MAP,
    ST_READ,
    ST_RESP
  } state_e;

endpackage

/* rtl/matrix_ring_rotator_core.sv */
// A write is stored on accept and busy_o stays low; one write per cycle while idle.
// A read of an element off the ring, or of a degenerate ring, steps through
// ST_LOCATE, ST_READ and ST_RESP; on the ring it adds ST_DIV (the 16-step bit-serial
// remainder), ST_WRAP, ST_POS and ST_MAP. A new read is taken only after the last done_o.
// Reset clears the sequencer and the configuration registers; the store is undefined.
// Results are shown for one cycle on done_o; the receiver cannot stall.
// ---------------------------------------------------------------------------
// matrix_ring_rotator_core
// Matrix store read as if one ring had been rotated, using a small sequencer
// around a shared remainder, wrap and mapping datapath.
// ---------------------------------------------------------------------------
module matrix_ring_rotator_core
  import mrr_pkg::*;
#(
  parameter int MAX_ROWS = DefMaxRows,
  parameter int MAX_COLS = DefMaxCols
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // command channel
  input  logic               start_i,
  output logic               busy_o,
  input  logic               command_i,
  input  logic [5:0]         row_index_i,
  input  logic [5:0]         col_index_i,
  input  logic signed [31:0] write_value_i,
  // result channel
  output logic               done_o,
  output logic signed [31:0] read_value_o,
  output logic               ring_invalid_o,
  // configuration channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  localparam int Depth = MAX_ROWS * MAX_COLS;
  localparam int AddrW = $clog2(Depth);
  localparam int CntW  = $clog2(DivSteps);
  localparam logic [6:0] RowCap = (MAX_ROWS > 127) ? 7'd127 : 7'(MAX_ROWS);
  localparam logic [6:0] ColCap = (MAX_COLS > 127) ? 7'd127 : 7'(MAX_COLS);

  state_e state_q, state_d;

  logic [6:0]         num_rows_q, num_cols_q;
  logic [5:0]         ring_number_q;
  logic signed [15:0] rotate_by_q;

  logic [5:0]         row_q, col_q;
  logic [9:0]         k_q, off_q, q_q;
  logic [8:0]         rem_q;
  logic [15:0]        dvd_q;
  logic [CntW-1:0]    cnt_q;
  logic [9:0]         pos_row_q, pos_col_q;
  logic               inv_q, zero_q;
  logic [31:0]        rdata_q;
  logic [31:0]        mem_q [Depth];

  logic               wr_fire;
  logic [6:0]         rows_use, cols_use;
  coord_t             min_rc, max_r, max_c, h, w, hw, h2w;
  coord_t             row_s, col_s, k_s, q_s, sr, sc;
  logic               ring_bad, on_ring, addr_oob;
  logic [9:0]         ring_len, trial, off_d;
  logic [10:0]        pos_sum;
  logic [AddrW-1:0]   wr_addr, rd_addr;

  assign cfg_ready_o = 1'b1;
  assign wr_fire     = (state_q == ST_IDLE) && start_i && (command_i == CMD_WRITE);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q    <= 7'd1;
      num_cols_q    <= 7'd1;
      ring_number_q <= 6'd1;
      rotate_by_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_NUM_ROWS:    num_rows_q    <= cfg_data_i[6:0];
        REG_NUM_COLS:    num_cols_q    <= cfg_data_i[6:0];
        REG_RING_NUMBER: ring_number_q <= cfg_data_i[5:0];
        REG_ROTATE_BY:   rotate_by_q   <= $signed(cfg_data_i);
        default:         ;
      endcase
    end
  end

  // Ring geometry from the configuration
  always_comb begin
    rows_use = (num_rows_q > RowCap) ? RowCap : num_rows_q;
    cols_use = (num_cols_q > ColCap) ? ColCap : num_cols_q;
    min_rc   = coord_t'({4'b0, ring_number_q}) - 10'sd1;
    max_r    = coord_t'({3'b0, rows_use}) - coord_t'({4'b0, ring_number_q});
    max_c    = coord_t'({3'b0, cols_use}) - coord_t'({4'b0, ring_number_q});
    ring_bad = (ring_number_q == '0) || (max_r <= min_rc) || (max_c <= min_rc);
    h        = max_r - min_rc;
    w        = max_c - min_rc;
    hw       = h + w;
    h2w      = hw + h;
    ring_len = {hw[8:0], 1'b0};
  end

  // Locate the addressed element on the walk
  always_comb begin
    row_s   = coord_t'({4'b0, row_q});
    col_s   = coord_t'({4'b0, col_q});
    on_ring = 1'b1;
    k_s     = '0;
    priority if (col_s == min_rc && row_s >= min_rc && row_s <= max_r) begin
      k_s = row_s - min_rc;
    end else if (row_s == max_r && col_s > min_rc && col_s <= max_c) begin
      k_s = h + (col_s - min_rc);
    end else if (col_s == max_c && row_s >= min_rc && row_s < max_r) begin
      k_s = hw + (max_r - row_s);
    end else if (row_s == min_rc && col_s > min_rc && col_s < max_c) begin
      k_s = h2w + (max_c - col_s);
    end else begin
      on_ring = 1'b0;
    end
    addr_oob = (int'(row_q) >= MAX_ROWS) || (int'(col_q) >= MAX_COLS);
  end

  // Remainder step, wrap offset and rotated position
  always_comb begin
    trial   = {rem_q, dvd_q[15]};
    off_d   = (rotate_by_q[15] && (rem_q != '0)) ? {1'b0, rem_q}
                                                  : ring_len - {1'b0, rem_q};
    pos_sum = {1'b0, k_q} + {1'b0, off_q};
    q_s     = coord_t'(q_q);
    priority if (q_s <= h) begin
      sr = min_rc + q_s;
      sc = min_rc;
    end else if (q_s <= hw) begin
      sr = max_r;
      sc = min_rc + (q_s - h);
    end else if (q_s <= h2w) begin
      sr = max_r - (q_s - hw);
      sc = max_c;
    end else begin
      sr = min_rc;
      sc = max_c - (q_s - h2w);
    end
  end

  // Store addresses
  assign wr_addr = AddrW'(row_index_i) * AddrW'(MAX_COLS) + AddrW'(col_index_i);
  assign rd_addr = AddrW'(pos_row_q) * AddrW'(MAX_COLS) + AddrW'(pos_col_q);

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i && command_i == CMD_READ) state_d = ST_LOCATE;
      end
      ST_LOCATE: begin
        state_d = (ring_bad || !on_ring) ? ST_READ : ST_DIV;
      end
      ST_DIV: begin
        if (cnt_q == '0) state_d = ST_WRAP;
      end
      ST_WRAP: state_d = ST_POS;
      ST_POS:  state_d = ST_MAP;
      ST_MAP:  state_d = ST_READ;
      ST_READ: state_d = ST_RESP;
      ST_RESP: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        row_q <= row_index_i;
        col_q <= col_index_i;
      end
      ST_LOCATE: begin
        inv_q     <= ring_bad;
        zero_q    <= (ring_bad || !on_ring) && addr_oob;
        pos_row_q <= {4'b0, row_q};
        pos_col_q <= {4'b0, col_q};
        k_q       <= 10'(k_s);
        rem_q     <= '0;
        dvd_q     <= rotate_by_q[15] ? 16'(-rotate_by_q) : rotate_by_q;
        cnt_q     <= CntW'(DivSteps - 1);
      end
      ST_DIV: begin
        // restoring remainder, one bit of |rotate_by| a cycle
        rem_q <= (trial >= ring_len) ? 9'(trial - ring_len) : trial[8:0];
        dvd_q <= {dvd_q[14:0], 1'b0};
        cnt_q <= cnt_q - 1'b1;
      end
      ST_WRAP: off_q <= off_d;
      ST_POS: begin
        q_q <= (pos_sum >= {1'b0, ring_len}) ? 10'(pos_sum - {1'b0, ring_len})
                                             : pos_sum[9:0];
      end
      ST_MAP: begin
        pos_row_q <= 10'(sr);
        pos_col_q <= 10'(sc);
      end
      ST_READ: rdata_q <= mem_q[rd_addr];
      ST_RESP: ;
      default: ;
    endcase
  end

  // Store write
  always_ff @(posedge clk_i) begin
    if (wr_fire && int'(row_index_i) < MAX_ROWS && int'(col_index_i) < MAX_COLS) begin
      mem_q[wr_addr] <= write_value_i;
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign done_o         = (state_q == ST_RESP);
  assign read_value_o   = zero_q ? '0 : $signed(rdata_q);
  assign ring_invalid_o = inv_q;

endmodule

/* rtl/mrr_checker.sv */
// ---------------------------------------------------------------------------
// mrr_checker
// Port-level checks of the command and result timing of the rotator.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mrr_checker
  import mrr_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic command_i,
  input logic busy_o,
  input logic done_o
);

  // a result is shown only while an item is in flight
  `ASSERT_NEVER(a_done_idle, clk_i, rst_ni, done_o && !busy_o)
  // each result strobe lasts one cycle
  `ASSERT_AT(a_done_single, clk_i, rst_ni, done_o |=> !done_o)
  // an accepted read raises busy
  `ASSERT_AT(a_read_busy, clk_i, rst_ni,
             (start_i && !busy_o && command_i == CMD_READ) |=> busy_o)
  // an accepted write leaves the block ready
  `ASSERT_AT(a_write_free, clk_i, rst_ni,
             (start_i && !busy_o && command_i == CMD_WRITE) |=> !busy_o)
  // busy drops only after the result strobe
  `ASSERT_AT(a_busy_end, clk_i, rst_ni, $fell(busy_o) |-> $past(done_o))

endmodule

bind matrix_ring_rotator_core mrr_checker u_mrr_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start_i   (start_i),
  .command_i (command_i),
  .busy_o    (busy_o),
  .done_o    (done_o)
);

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// matrix_ring_rotator_core testbench
// Drives write and read commands through several matrix and ring settings.
// Reads are checked against a local model of the rotated ring or the plan.
// A short directed plan covers the field extremes and degenerate rings.
// Random phases follow with sender gaps and register rewrites between them.
// ---------------------------------------------------------------------------
module testbench;
  import mrr_pkg::*;

  localparam int RandItems = 1150;
  localparam int Settle    = 30;    // longer than the slowest read
  localparam int StallMax  = 2000;  // cycles without progress before abort
  localparam int StoreSize = DefMaxRows * DefMaxCols;

  typedef struct {
    logic signed [31:0] value;
    logic               invalid;
  } read_result_t;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  reg_idx;
    logic [15:0] reg_val;
    logic        cmd;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [31:0] value;
    bit          typed;
    logic [31:0] typed_val;
    logic        typed_inv;
  } plan_row_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               start_i        = 1'b0;
  logic               command_i      = CMD_WRITE;
  logic [5:0]         row_index_i    = '0;
  logic [5:0]         col_index_i    = '0;
  logic signed [31:0] write_value_i  = '0;
  logic               cfg_valid_i    = 1'b0;
  logic [1:0]         cfg_index_i    = REG_NUM_ROWS;
  logic [15:0]        cfg_data_i     = '0;
  logic               busy_o;
  logic               done_o;
  logic signed [31:0] read_value_o;
  logic               ring_invalid_o;
  logic               cfg_ready_o;

  // Local copy of the store and of the registers
  logic [31:0]        store_mem [StoreSize];
  bit                 written   [StoreSize];
  logic [6:0]         cfg_rows  = 7'd1;
  logic [6:0]         cfg_cols  = 7'd1;
  logic [5:0]         cfg_ring  = 6'd1;
  logic signed [15:0] cfg_rot   = '0;

  read_result_t pending_reads[$];
  int           mismatches   = 0;
  int           items_sent   = 0;
  int           stall_cycles = 0;

  matrix_ring_rotator_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .command_i      (command_i),
    .row_index_i    (row_index_i),
    .col_index_i    (col_index_i),
    .write_value_i  (write_value_i),
    .done_o         (done_o),
    .read_value_o   (read_value_o),
    .ring_invalid_o (ring_invalid_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Corners of the selected ring; returns 0 for a degenerate ring
  function automatic bit ring_shape(output int minr, output int minc,
                                    output int maxr, output int maxc);
    int n, m, s;
    n = (cfg_rows > DefMaxRows) ? DefMaxRows : int'(cfg_rows);
    m = (cfg_cols > DefMaxCols) ? DefMaxCols : int'(cfg_cols);
    s = int'(cfg_ring);
    minr = s - 1;
    minc = s - 1;
    maxr = n - s;
    maxc = m - s;
    return (s != 0 && maxr > minr && maxc > minc);
  endfunction

  // Position of walk index q, counterclockwise from the top-left corner
  function automatic void walk_to_pos(input int q, input int minr, input int minc,
                                      input int maxr, input int maxc,
                                      output int r, output int c);
    int h, w;
    h = maxr - minr;
    w = maxc - minc;
    if (q <= h) begin
      r = minr + q;
      c = minc;
    end else if (q <= h + w) begin
      r = maxr;
      c = minc + (q - h);
    end else if (q <= 2 * h + w) begin
      r = maxr - (q - h - w);
      c = maxc;
    end else begin
      r = minr;
      c = maxc - (q - 2 * h - w);
    end
  endfunction

  // Store entry that a read of (row, col) returns after the ring rotation
  function automatic void rotated_source(input int row, input int col,
                                         output int sr, output int sc,
                                         output logic invalid);
    int minr, minc, maxr, maxc, h, w, len, k, rm;
    sr = row;
    sc = col;
    invalid = 1'b0;
    if (!ring_shape(minr, minc, maxr, maxc)) begin
      invalid = 1'b1;
      return;
    end
    h = maxr - minr;
    w = maxc - minc;
    len = 2 * (h + w);
    if (col == minc && row >= minr && row <= maxr) k = row - minr;
    else if (row == maxr && col > minc && col <= maxc) k = h + (col - minc);
    else if (col == maxc && row >= minr && row < maxr) k = h + w + (maxr - row);
    else if (row == minr && col > minc && col < maxc) k = 2 * h + w + (maxc - col);
    else return;
    rm = int'(cfg_rot) % len;
    if (rm < 0) rm += len;
    walk_to_pos((k + len - rm) % len, minr, minc, maxr, maxc, sr, sc);
  endfunction

  // Present one item, hold it until accepted, then update the model
  task automatic send_item(input logic cmd, input logic [5:0] row, input logic [5:0] col,
                           input logic [31:0] val, input bit typed,
                           input logic [31:0] typed_val, input logic typed_inv);
    int sr, sc;
    logic inv;
    read_result_t res;
    start_i       <= 1'b1;
    command_i     <= cmd;
    row_index_i   <= row;
    col_index_i   <= col;
    write_value_i <= val;
    do @(posedge clk_i); while (busy_o);
    items_sent++;
    if (cmd == CMD_WRITE) begin
      store_mem[row * DefMaxCols + col] = val;
      written[row * DefMaxCols + col]   = 1'b1;
    end else begin
      rotated_source(row, col, sr, sc, inv);
      res.value   = typed ? typed_val : store_mem[sr * DefMaxCols + sc];
      res.invalid = typed ? typed_inv : inv;
      pending_reads.push_back(res);
    end
  endtask

  // Fill the source entry first so that a read never hits an unwritten word
  task automatic issue(input logic cmd, input logic [5:0] row, input logic [5:0] col,
                       input logic [31:0] val, input bit typed,
                       input logic [31:0] typed_val, input logic typed_inv);
    int sr, sc;
    logic inv;
    if (cmd == CMD_READ) begin
      rotated_source(row, col, sr, sc, inv);
      if (!written[sr * DefMaxCols + sc])
        send_item(CMD_WRITE, 6'(sr), 6'(sc), $urandom, 1'b0, '0, 1'b0);
    end
    send_item(cmd, row, col, val, typed, typed_val, typed_inv);
  endtask

  // Drop start and scramble the idle payload for a number of cycles
  task automatic hold_off(input int cycles);
    start_i       <= 1'b0;
    command_i     <= 1'($urandom);
    row_index_i   <= 6'($urandom);
    col_index_i   <= 6'($urandom);
    write_value_i <= $urandom;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Stop sending and wait for every outstanding read to return
  task automatic drain();
    start_i <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  // Write one register once the block is idle
  task automatic set_reg(input logic [1:0] idx, input logic [15:0] val);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_NUM_ROWS:    cfg_rows = val[6:0];
      REG_NUM_COLS:    cfg_cols = val[6:0];
      REG_RING_NUMBER: cfg_ring = val[5:0];
      REG_ROTATE_BY:   cfg_rot  = val;
      default: ;
    endcase
  endtask

  function automatic plan_row_t pr_cfg(input logic [1:0] idx, input logic [15:0] val);
    plan_row_t p;
    p = '{default: '0};
    p.is_cfg  = 1'b1;
    p.reg_idx = idx;
    p.reg_val = val;
    return p;
  endfunction

  function automatic plan_row_t pr_item(input logic cmd, input logic [5:0] row,
                                        input logic [5:0] col, input logic [31:0] val);
    plan_row_t p;
    p = '{default: '0};
    p.cmd   = cmd;
    p.row   = row;
    p.col   = col;
    p.value = val;
    return p;
  endfunction

  function automatic plan_row_t pr_check(input logic [5:0] row, input logic [5:0] col,
                                         input logic [31:0] exp_val, input logic exp_inv);
    plan_row_t p;
    p = pr_item(CMD_READ, row, col, 32'h0);
    p.typed     = 1'b1;
    p.typed_val = exp_val;
    p.typed_inv = exp_inv;
    return p;
  endfunction

  // Compare each result with the oldest outstanding read
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_reads.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: expected none, actual value %0d invalid %0b",
                 $time, read_value_o, ring_invalid_o);
      end else begin
        if (read_value_o !== pending_reads[0].value) begin
          mismatches++;
          $display("%0t: read_value mismatch: expected %0d, actual %0d",
                   $time, pending_reads[0].value, read_value_o);
        end
        if (ring_invalid_o !== pending_reads[0].invalid) begin
          mismatches++;
          $display("%0t: ring_invalid mismatch: expected %0b, actual %0b",
                   $time, pending_reads[0].invalid, ring_invalid_o);
        end
        void'(pending_reads.pop_front());
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallMax) begin
      $display("%0t: no progress for %0d cycles", $time, StallMax);
      $display("matrix_ring_rotator_core regression: fail");
      $finish;
    end
  end

  initial begin
    plan_row_t   plan[$];
    int          phase_no;
    int          phase_len;
    int          pick;
    int          nr, nc, k;
    int          minr, minc, maxr, maxc, r, c;
    bit          idle_on;
    logic        cmd;
    logic [5:0]  row, col;
    logic [15:0] rot;

    // Degenerate 1x1 ring after reset: reads return the stored word, flagged
    plan.push_back(pr_item(CMD_WRITE, 6'd0, 6'd0, 32'h7FFF_FFFF));
    plan.push_back(pr_check(6'd0, 6'd0, 32'h7FFF_FFFF, 1'b1));
    plan.push_back(pr_item(CMD_WRITE, 6'd63, 6'd63, 32'h8000_0000));
    plan.push_back(pr_check(6'd63, 6'd63, 32'h8000_0000, 1'b1));
    plan.push_back(pr_item(CMD_WRITE, 6'd0, 6'd63, 32'h0));
    plan.push_back(pr_item(CMD_WRITE, 6'd63, 6'd0, 32'hFFFF_FFFF));
    plan.push_back(pr_check(6'd0, 6'd63, 32'h0, 1'b1));
    plan.push_back(pr_check(6'd63, 6'd0, 32'hFFFF_FFFF, 1'b1));
    // 2x2 ring rotated by one, then the other way
    plan.push_back(pr_cfg(REG_NUM_ROWS, 16'd2));
    plan.push_back(pr_cfg(REG_NUM_COLS, 16'd2));
    plan.push_back(pr_cfg(REG_ROTATE_BY, 16'd1));
    plan.push_back(pr_item(CMD_WRITE, 6'd1, 6'd0, 32'd1));
    plan.push_back(pr_item(CMD_WRITE, 6'd1, 6'd1, 32'd2));
    plan.push_back(pr_item(CMD_WRITE, 6'd0, 6'd1, 32'd3));
    plan.push_back(pr_item(CMD_READ, 6'd1, 6'd0, 32'h0));
    plan.push_back(pr_item(CMD_READ, 6'd0, 6'd0, 32'h0));
    plan.push_back(pr_item(CMD_READ, 6'd63, 6'd63, 32'h0));
    plan.push_back(pr_cfg(REG_ROTATE_BY, 16'hFFFF));
    plan.push_back(pr_item(CMD_READ, 6'd1, 6'd0, 32'h0));
    // Ring beyond the centre, ring zero, zero rows
    plan.push_back(pr_cfg(REG_RING_NUMBER, 16'd2));
    plan.push_back(pr_check(6'd1, 6'd1, 32'd2, 1'b1));
    plan.push_back(pr_cfg(REG_RING_NUMBER, 16'd0));
    plan.push_back(pr_check(6'd0, 6'd1, 32'd3, 1'b1));
    plan.push_back(pr_cfg(REG_RING_NUMBER, 16'd1));
    plan.push_back(pr_cfg(REG_NUM_ROWS, 16'd0));
    plan.push_back(pr_check(6'd0, 6'd0, 32'h7FFF_FFFF, 1'b1));
    // Sizes above the store clamp; most negative and most positive rotation
    plan.push_back(pr_cfg(REG_NUM_ROWS, 16'd127));
    plan.push_back(pr_cfg(REG_NUM_COLS, 16'd127));
    plan.push_back(pr_cfg(REG_ROTATE_BY, 16'h8000));
    plan.push_back(pr_item(CMD_READ, 6'd0, 6'd0, 32'h0));
    plan.push_back(pr_item(CMD_READ, 6'd63, 6'd63, 32'h0));
    plan.push_back(pr_cfg(REG_RING_NUMBER, 16'd32));
    plan.push_back(pr_cfg(REG_ROTATE_BY, 16'h7FFF));
    plan.push_back(pr_item(CMD_READ, 6'd31, 6'd31, 32'h0));
    plan.push_back(pr_item(CMD_READ, 6'd32, 6'd32, 32'h0));
    // Single row matrix
    plan.push_back(pr_cfg(REG_NUM_ROWS, 16'd1));
    plan.push_back(pr_cfg(REG_NUM_COLS, 16'd64));
    plan.push_back(pr_cfg(REG_RING_NUMBER, 16'd1));
    plan.push_back(pr_check(6'd0, 6'd63, 32'h0, 1'b1));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed plan back to back
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        set_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        issue(plan[i].cmd, plan[i].row, plan[i].col, plan[i].value,
              plan[i].typed, plan[i].typed_val, plan[i].typed_inv);
      end
    end

    // Random phases, each with fresh register settings
    phase_no = 0;
    while (items_sent < RandItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        nr = $urandom_range(1, 10);
        nc = $urandom_range(1, 10);
      end else if (pick < 90) begin
        nr = $urandom_range(30, 64);
        nc = $urandom_range(30, 64);
      end else begin
        nr = $urandom_range(0, 127);
        nc = $urandom_range(0, 127);
      end
      set_reg(REG_NUM_ROWS, 16'(nr));
      set_reg(REG_NUM_COLS, 16'(nc));
      nr = (nr > DefMaxRows) ? DefMaxRows : ((nr == 0) ? 1 : nr);
      nc = (nc > DefMaxCols) ? DefMaxCols : ((nc == 0) ? 1 : nc);
      k = ((nr < nc) ? nr : nc) / 2;
      set_reg(REG_RING_NUMBER, ($urandom_range(0, 99) < 85 && k > 0) ?
              16'($urandom_range(1, k)) : 16'($urandom_range(0, 63)));
      pick = $urandom_range(0, 99);
      if (pick < 50) rot = 16'($signed($urandom_range(0, 20)) - 10);
      else if (pick < 80) rot = 16'($urandom);
      else if (pick < 90) rot = 16'h8000;
      else rot = 16'h7FFF;
      set_reg(REG_ROTATE_BY, rot);

      phase_len = $urandom_range(40, 120);
      idle_on = (phase_no % 4 != 2);
      for (int i = 0; i < phase_len && items_sent < RandItems; i++) begin
        // Sender gap, mostly short, sometimes longer than a whole read
        if (idle_on && $urandom_range(0, 99) < 26)
          hold_off(($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) : $urandom_range(4, 30));
        // Let the block empty out halfway through some phases
        if (i == phase_len / 2 && phase_no % 3 == 0) drain();
        pick = $urandom_range(0, 99);
        row = 6'($urandom);
        col = 6'($urandom);
        cmd = CMD_READ;
        if (pick < 25) begin
          cmd = CMD_WRITE;
          if ($urandom_range(0, 1) == 1) begin
            row = 6'($urandom_range(0, nr - 1));
            col = 6'($urandom_range(0, nc - 1));
          end
        end else if (pick < 75 && ring_shape(minr, minc, maxr, maxc)) begin
          k = $urandom_range(0, 2 * ((maxr - minr) + (maxc - minc)) - 1);
          walk_to_pos(k, minr, minc, maxr, maxc, r, c);
          row = 6'(r);
          col = 6'(c);
        end else if (pick < 90) begin
          row = 6'($urandom_range(0, nr - 1));
          col = 6'($urandom_range(0, nc - 1));
        end
        issue(cmd, row, col, $urandom, 1'b0, '0, 1'b0);
      end
      phase_no++;
    end

    drain();
    if (mismatches == 0) begin
      $display("matrix_ring_rotator_core regression: pass");
    end else begin
      $display("matrix_ring_rotator_core regression: fail");
    end
    $finish;
  end

endmodule

/* matrix_ring_rotator_core.f */
+incdir+rtl
rtl/mrr_pkg.sv
rtl/matrix_ring_rotator_core.sv
rtl/mrr_checker.sv
verif/testbench.sv
